>>> design/shortest_remaining_time_scheduler_defines.svh
// Assertion macros for the scheduler RTL.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/srts_pkg.sv
// Types, codes and helper functions of the shortest-remaining-time scheduler.
package srts_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_UPDATE,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_UPDATE,
        OP_SHIFT
    } t_cell_op;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_RAN    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;

    localparam logic [7:0] QUANTUM_RESET = 8'd5;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] total;
        logic [16:0] elapsed;
        logic [15:0] quanta;
    } t_entry;

    // Running best candidate handed from cell to cell during a scan.
    typedef struct packed {
        logic        found;
        t_entry      ent;
        logic [15:0] rem;
    } t_carry;

    function automatic logic [15:0] remaining(input t_entry e);
        remaining = (e.elapsed < {1'b0, e.total}) ? (e.total - e.elapsed[15:0]) : 16'd0;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

>>> design/srts_cell.sv
// One table slot: holds a process entry, joins the min-remaining scan, shifts on removal.
module srts_cell #(
    parameter  int DEPTH = 32,
    parameter  int IDX   = 0,
    localparam int IW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srts_pkg::t_cell_op i_op,
    input  logic [IW-1:0]     i_sel,
    input  logic [CW-1:0]     i_count,
    input  logic [7:0]        i_load_id,
    input  logic [15:0]       i_load_total,
    input  logic [7:0]        i_quantum,
    input  srts_pkg::t_entry  i_nb,
    output srts_pkg::t_entry  o_entry,
    input  logic              i_tok,
    output logic              o_tok,
    input  srts_pkg::t_carry  i_carry,
    input  logic [IW-1:0]     i_carry_idx,
    output srts_pkg::t_carry  o_carry,
    output logic [IW-1:0]     o_carry_idx
);

    srts_pkg::t_entry r_ent;
    srts_pkg::t_carry r_carry;
    logic [IW-1:0]    r_cidx;
    logic             r_tok;
    logic [15:0]      w_rem;
    logic             w_resident;
    logic             w_take;

    assign w_rem      = srts_pkg::remaining(r_ent);
    assign w_resident = CW'(IDX) < i_count;
    // strict less-than keeps the entry nearest the head on a tie
    assign w_take     = w_resident && (!i_carry.found || (w_rem < i_carry.rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            if (w_take) begin
                r_carry <= '{found: 1'b1, ent: r_ent, rem: w_rem};
                r_cidx  <= IW'(IDX);
            end else begin
                r_carry <= i_carry;
                r_cidx  <= i_carry_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            srts_pkg::OP_LOAD: begin
                if (CW'(IDX) == i_count) begin
                    r_ent <= '{id: i_load_id, total: i_load_total,
                               elapsed: 17'd0, quanta: 16'd0};
                end
            end
            srts_pkg::OP_UPDATE: begin
                if (w_resident) begin
                    r_ent.quanta <= srts_pkg::sat_inc16(r_ent.quanta);
                end
                if (IW'(IDX) == i_sel) begin
                    r_ent.elapsed <= r_ent.elapsed + {9'd0, i_quantum};
                end
            end
            srts_pkg::OP_SHIFT: begin
                // close the gap left by the removed entry
                if (IW'(IDX) >= i_sel) begin
                    r_ent <= i_nb;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry     = r_ent;
    assign o_tok       = r_tok;
    assign o_carry     = r_carry;
    assign o_carry_idx = r_cidx;

endmodule

>>> design/shortest_remaining_time_scheduler.sv
// Top level: command sequencer over a chain of table cells.
//
//   channel | signals                                   | beat when
//   --------+-------------------------------------------+-----------------------------
//   in      | i_cmd i_proc_id i_duration                | i_in_valid & o_in_ready
//   out     | o_status o_ran_id ... o_resident_count    | o_out_valid & i_out_ready
//   cfg     | i_cfg_wdata (quantum)                     | i_cfg_we
//
// A load or a rejected/idle command runs DECIDE, then DONE, where the result register loads.
// A tick runs DECIDE, SCAN, UPDATE, SHIFT (if the process finishes), DONE: the search token
//   walks the cell chain one cell per cycle, then update and removal shift. Input opens
// again when the result register loads.
// Reset clears the count, the quanta sum and sets quantum to 5; table cells are not cleared.
// A stalled result holds in the output register while the next item is accepted.
`include "shortest_remaining_time_scheduler_defines.svh"

module shortest_remaining_time_scheduler #(
    parameter  int TABLE_DEPTH = 32,
    localparam int IW          = $clog2(TABLE_DEPTH),
    localparam int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_proc_id,
    input  logic [15:0] i_duration,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_ran_id,
    output logic [15:0] o_remaining_before,
    output logic        o_finished,
    output logic [15:0] o_finished_quanta,
    output logic [31:0] o_quanta_sum,
    output logic [5:0]  o_resident_count
);

    srts_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_sum;
    logic [7:0]         r_quantum;
    logic               r_cmd;
    logic [7:0]         r_id;
    logic [15:0]        r_dur;
    srts_pkg::t_carry   r_best;
    logic [IW-1:0]      r_best_idx;
    logic [1:0]         r_res_status;
    logic [7:0]         r_res_ran;
    logic [15:0]        r_res_rem;
    logic               r_res_fin;
    logic [15:0]        r_res_fq;
    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic [7:0]         r_o_ran;
    logic [15:0]        r_o_rem;
    logic               r_o_fin;
    logic [15:0]        r_o_fq;
    logic [31:0]        r_o_sum;
    logic [5:0]         r_o_count;

    srts_pkg::t_cell_op w_op;
    logic               w_start;
    logic               w_full;
    logic               w_empty;
    logic               w_out_free;
    logic [16:0]        w_new_el;
    logic               w_fin;
    logic [15:0]        w_fq;
    logic [32:0]        w_sum_ext;
    logic [TABLE_DEPTH:0] w_tok;
    srts_pkg::t_carry   w_carry [TABLE_DEPTH+1];
    logic [IW-1:0]      w_cidx  [TABLE_DEPTH+1];
    srts_pkg::t_entry   w_ent   [TABLE_DEPTH+1];

    assign w_full     = r_count == CW'(TABLE_DEPTH);
    assign w_empty    = r_count == '0;
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_new_el   = r_best.ent.elapsed + {9'd0, r_quantum};
    assign w_fin      = w_new_el >= {1'b0, r_best.ent.total};
    assign w_fq       = srts_pkg::sat_inc16(r_best.ent.quanta);
    assign w_sum_ext  = {1'b0, r_sum} + {17'd0, w_fq};

    assign w_tok[0]                = w_start;
    assign w_carry[0]              = '0;
    assign w_cidx[0]               = '0;
    assign w_ent[TABLE_DEPTH]      = '0;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        srts_cell #(
            .DEPTH (TABLE_DEPTH),
            .IDX   (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_sel        (r_best_idx),
            .i_count      (r_count),
            .i_load_id    (r_id),
            .i_load_total (r_dur),
            .i_quantum    (r_quantum),
            .i_nb         (w_ent[k+1]),
            .o_entry      (w_ent[k]),
            .i_tok        (w_tok[k]),
            .o_tok        (w_tok[k+1]),
            .i_carry      (w_carry[k]),
            .i_carry_idx  (w_cidx[k]),
            .o_carry      (w_carry[k+1]),
            .o_carry_idx  (w_cidx[k+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srts_pkg::S_IDLE: begin
                if (i_in_valid) n_state = srts_pkg::S_DECIDE;
            end
            srts_pkg::S_DECIDE: begin
                if (r_cmd == srts_pkg::CMD_TICK && !w_empty) n_state = srts_pkg::S_SCAN;
                else                                          n_state = srts_pkg::S_DONE;
            end
            srts_pkg::S_SCAN: begin
                if (w_tok[TABLE_DEPTH]) n_state = srts_pkg::S_UPDATE;
            end
            srts_pkg::S_UPDATE: begin
                n_state = w_fin ? srts_pkg::S_SHIFT : srts_pkg::S_DONE;
            end
            srts_pkg::S_SHIFT: begin
                n_state = srts_pkg::S_DONE;
            end
            srts_pkg::S_DONE: begin
                if (w_out_free) n_state = srts_pkg::S_IDLE;
            end
            default: n_state = srts_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_op       = srts_pkg::OP_NOP;
        w_start    = 1'b0;
        unique case (r_state)
            srts_pkg::S_IDLE: o_in_ready = 1'b1;
            srts_pkg::S_DECIDE: begin
                if (r_cmd == srts_pkg::CMD_LOAD && !w_full) w_op = srts_pkg::OP_LOAD;
                if (r_cmd == srts_pkg::CMD_TICK && !w_empty) w_start = 1'b1;
            end
            srts_pkg::S_UPDATE: w_op = srts_pkg::OP_UPDATE;
            srts_pkg::S_SHIFT:  w_op = srts_pkg::OP_SHIFT;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srts_pkg::S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_quantum <= srts_pkg::QUANTUM_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_quantum <= i_cfg_wdata;
            if (w_op == srts_pkg::OP_LOAD)  r_count <= r_count + CW'(1);
            if (w_op == srts_pkg::OP_SHIFT) r_count <= r_count - CW'(1);
            if (r_state == srts_pkg::S_UPDATE && w_fin) begin
                r_sum <= w_sum_ext[32] ? 32'hFFFF_FFFF : w_sum_ext[31:0];
            end
            if (r_state == srts_pkg::S_DONE && w_out_free) r_o_valid <= 1'b1;
            else if (i_out_ready)                          r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == srts_pkg::S_IDLE && i_in_valid) begin
            r_cmd <= i_cmd;
            r_id  <= i_proc_id;
            r_dur <= i_duration;
        end
        if (r_state == srts_pkg::S_DECIDE) begin
            r_res_ran <= '0;
            r_res_rem <= '0;
            r_res_fin <= 1'b0;
            r_res_fq  <= '0;
            if (r_cmd == srts_pkg::CMD_LOAD) begin
                r_res_status <= w_full ? srts_pkg::ST_FULL : srts_pkg::ST_LOADED;
            end else begin
                r_res_status <= w_empty ? srts_pkg::ST_IDLE : srts_pkg::ST_RAN;
            end
        end
        // hold the winner once the token leaves the last cell
        if (r_state == srts_pkg::S_SCAN && w_tok[TABLE_DEPTH]) begin
            r_best     <= w_carry[TABLE_DEPTH];
            r_best_idx <= w_cidx[TABLE_DEPTH];
        end
        if (r_state == srts_pkg::S_UPDATE) begin
            r_res_ran <= r_best.ent.id;
            r_res_rem <= r_best.rem;
            r_res_fin <= w_fin;
            r_res_fq  <= w_fin ? w_fq : 16'd0;
        end
        if (r_state == srts_pkg::S_DONE && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_ran    <= r_res_ran;
            r_o_rem    <= r_res_rem;
            r_o_fin    <= r_res_fin;
            r_o_fq     <= r_res_fq;
            r_o_sum    <= r_sum;
            r_o_count  <= 6'(r_count);
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_status           = r_o_status;
    assign o_ran_id           = r_o_ran;
    assign o_remaining_before = r_o_rem;
    assign o_finished         = r_o_fin;
    assign o_finished_quanta  = r_o_fq;
    assign o_quanta_sum       = r_o_sum;
    assign o_resident_count   = r_o_count;

    `SRTS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(TABLE_DEPTH), "count past table depth")
    `SRTS_ASSERT_IMP(a_tok_single, 1'b1, $onehot0(w_tok), "more than one scan token in the chain")
    `SRTS_ASSERT_IMP(a_tok_end_in_scan, w_tok[TABLE_DEPTH], r_state == srts_pkg::S_SCAN, "scan token outside scan")
    `SRTS_ASSERT_NXT(a_accept_decide, i_in_valid && o_in_ready, r_state == srts_pkg::S_DECIDE, "accepted beat not decoded")
    `SRTS_ASSERT_IMP(a_fin_is_run, o_out_valid && o_finished, o_status == srts_pkg::ST_RAN, "finished without a run")

endmodule
